FILE: sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants of the SHA-256 hash engine
// Round constants, initial hash values and the round helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  // Packed input word, carried from the front part to the back part
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } in_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StPack,
    StPad,
    StRound,
    StFinal,
    StEmit
  } core_state_e;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

FILE: sv/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front: input stage and word queue
// Accepts message words, clamps the byte count and queues them for the core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [31:0]      data_word_i,
  input  wire logic [2:0]       valid_bytes_i,
  input  wire logic             last_word_i,
  output logic                  item_valid_o,
  output sha_pkg::in_item_t     item_o,
  input  wire logic             item_take_i
);

  localparam int unsigned AW = $clog2(sha_pkg::QueueDepth);

  sha_pkg::in_item_t mem_q [sha_pkg::QueueDepth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;
  sha_pkg::in_item_t item_in;

  // Classify: clamp byte counts above four
  always_comb begin
    item_in.data   = data_word_i;
    item_in.nbytes = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
    item_in.last   = last_word_i;
  end

  assign full         = (cnt_q == (AW+1)'(sha_pkg::QueueDepth));
  assign do_push      = push && !full;
  assign item_valid_o = (cnt_q != '0);
  assign do_pop       = item_take_i && item_valid_o;
  assign item_o       = mem_q[rd_q];

  // Advance pointers
  always_comb begin
    wr_d  = do_push ? wr_q + AW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core: byte packing, padding and compression
// Packs one byte per cycle, runs one round per cycle, emits the digest.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  input  sha_pkg::in_item_t     item_i,
  output logic                  item_take_o,
  output logic                  empty,
  input  wire logic             pop,
  output logic [31:0]           digest_word_o,
  output logic [2:0]            word_index_o,
  output logic                  digest_last_o
);

  sha_pkg::core_state_e state_q, state_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  pos_q;
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;
  logic [2:0]  bsel_q;
  logic        pad_q;    // padding in progress
  logic        padb_q;   // 0x80 byte already placed
  logic [2:0]  oidx_q;
  logic [31:0] cur_q;
  logic [2:0]  nb_q;
  logic        last_q;

  logic        pack_done, byte_wr;
  logic [7:0]  byte_val;
  logic [31:0] w_new, t1, t2;

  // Select current byte
  always_comb begin
    byte_val = cur_q[31:24];
    if (pad_q) begin
      byte_val = padb_q ? 8'h00 : sha_pkg::PadByte;
    end
  end

  assign pack_done = (bsel_q == nb_q);

  // Schedule and round arithmetic
  always_comb begin
    logic [31:0] wt;
    w_new = w_q[rnd_q[3:0]] + sha_pkg::small_s0(w_q[4'(rnd_q[3:0] + 4'd1)])
          + w_q[4'(rnd_q[3:0] + 4'd9)] + sha_pkg::small_s1(w_q[4'(rnd_q[3:0] + 4'd14)]);
    wt = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]] : w_new;
    t1 = v_q[7] + sha_pkg::big_s1(v_q[4]) + (v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6])))
       + sha_pkg::RoundK[rnd_q] + wt;
    t2 = sha_pkg::big_s0(v_q[0]) + ((v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1])));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha_pkg::StIdle:  if (item_valid_i) state_d = sha_pkg::StPack;
      sha_pkg::StPack: begin
        if (!pack_done) begin
          if (pos_q == 6'd63) state_d = sha_pkg::StRound;
        end else if (last_q) begin
          state_d = sha_pkg::StPad;
        end else begin
          state_d = sha_pkg::StIdle;
        end
      end
      sha_pkg::StPad: begin
        if (padb_q && pos_q == 6'd56) state_d = sha_pkg::StRound;
        else if (pos_q == 6'd63) state_d = sha_pkg::StRound;
      end
      sha_pkg::StRound: if (rnd_q == 6'd63) state_d = sha_pkg::StFinal;
      sha_pkg::StFinal: begin
        if (pad_q && padb_q && pos_q == 6'd56 && last_q && bsel_q == 3'd7) begin
          state_d = sha_pkg::StEmit;
        end else if (pad_q) begin
          state_d = sha_pkg::StPad;
        end else begin
          state_d = sha_pkg::StPack;
        end
      end
      sha_pkg::StEmit: if (pop && oidx_q == 3'd7) state_d = sha_pkg::StIdle;
      default: state_d = sha_pkg::StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    item_take_o   = (state_q == sha_pkg::StIdle) && item_valid_i;
    empty         = (state_q != sha_pkg::StEmit);
    digest_word_o = h_q[oidx_q];
    word_index_o  = oidx_q;
    digest_last_o = (oidx_q == 3'd7);
  end

  assign byte_wr = (state_q == sha_pkg::StPack && !pack_done) ||
                   (state_q == sha_pkg::StPad && !(padb_q && pos_q == 6'd56));

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::StIdle;
      pos_q   <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      bsel_q  <= '0;
      pad_q   <= 1'b0;
      padb_q  <= 1'b0;
      oidx_q  <= '0;
      nb_q    <= '0;
      last_q  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::HashInit[i];
        v_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        sha_pkg::StIdle: begin
          if (item_valid_i) begin
            nb_q   <= item_i.nbytes;
            last_q <= item_i.last;
            bsel_q <= '0;
            bits_q <= bits_q + {58'd0, item_i.nbytes, 3'd0};
          end
        end
        sha_pkg::StPack: begin
          if (!pack_done) begin
            bsel_q <= bsel_q + 3'd1;
            pos_q  <= pos_q + 6'd1;
          end else if (last_q) begin
            pad_q  <= 1'b1;
            padb_q <= 1'b0;
          end
        end
        sha_pkg::StPad: begin
          if (padb_q && pos_q == 6'd56) begin
            bsel_q <= 3'd7;   // marks final block
          end else begin
            padb_q <= 1'b1;
            pos_q  <= pos_q + 6'd1;
          end
        end
        sha_pkg::StRound: begin
          rnd_q <= rnd_q + 6'd1;
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
        end
        sha_pkg::StFinal: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          oidx_q <= '0;
        end
        sha_pkg::StEmit: begin
          if (pop) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::HashInit[i];
              pos_q  <= '0;
              bits_q <= '0;
              pad_q  <= 1'b0;
              padb_q <= 1'b0;
              bsel_q <= '0;
              last_q <= 1'b0;
              nb_q   <= '0;
            end
          end
        end
        default: ;
      endcase
      // Load working vars when a block closes
      if (state_d == sha_pkg::StRound && state_q != sha_pkg::StRound) begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
        rnd_q <= '0;
      end
    end
  end

  // Block buffer and rolling schedule
  always_ff @(posedge clk_i) begin
    if (state_q == sha_pkg::StIdle && item_valid_i) begin
      cur_q <= item_i.data;
    end else if (state_q == sha_pkg::StPack && !pack_done) begin
      cur_q <= {cur_q[23:0], 8'h00};
    end
    if (byte_wr) begin
      case (pos_q[1:0])
        2'd0: w_q[pos_q[5:2]] <= {byte_val, 24'd0};
        2'd1: w_q[pos_q[5:2]][23:16] <= byte_val;
        2'd2: w_q[pos_q[5:2]][15:8] <= byte_val;
        default: w_q[pos_q[5:2]][7:0] <= byte_val;
      endcase
    end
    if (state_q == sha_pkg::StPad && padb_q && pos_q == 6'd56) begin
      w_q[14] <= bits_q[63:32];
      w_q[15] <= bits_q[31:0];
    end
    if (state_q == sha_pkg::StRound && rnd_q >= 6'd16) begin
      w_q[rnd_q[3:0]] <= w_new;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sha256_hash_engine_top.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_top: streaming SHA-256 engine
// Front queue of message words feeding a packing and compression core.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive data_word_i, valid_bytes_i, last_word_i and raise
//   push; a request is taken on a clock edge where push is high and full
//   is low. A four-entry queue holds requests while the core is busy.
//   Output channel: while empty is low the next digest word is on
//   digest_word_o with word_index_o, digest_last_o on the eighth; pop
//   takes it. Eight words are given per message after the last word.
//   Timing: the core packs one byte a cycle and takes a new word only from
//   its idle state; each 64-byte block then goes through the rounds and
//   hash update, done by the single round unit. Padding packs one byte a
//   cycle up to byte 56.
//   Reset loads the initial hash values and clears the queue and counts.
//   A stalled receiver holds the core in its digest phase; the queue keeps
//   accepting words until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_hash_engine_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  valid_bytes_i,
  input  wire logic        last_word_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             digest_last_o
);

  logic              item_valid, item_take;
  sha_pkg::in_item_t item;

  sha_front u_front (
    .clk_i, .rst_ni, .push, .full, .data_word_i, .valid_bytes_i, .last_word_i,
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .empty, .pop, .digest_word_o, .word_index_o, .digest_last_o
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking regression of the streaming SHA-256 engine
// Directed and random messages of mixed length and byte counts are pushed
// through the engine; a local SHA-256 predictor computes each digest, and
// every popped digest word is compared against the oldest predicted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [31:0] data_word_i;
  logic [2:0]  valid_bytes_i;
  logic        last_word_i;
  logic        empty;
  logic        pop;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        digest_last_o;

  sha256_hash_engine_top u_top (
    .clk_i, .rst_ni, .push, .full, .data_word_i, .valid_bytes_i, .last_word_i,
    .empty, .pop, .digest_word_o, .word_index_o, .digest_last_o
  );

  msg_word_t    pending_words[$];
  digest_word_t digest_expect[$];
  int           error_count;
  bit           hold_for_drain;
  int           stall_hold;

  // Predictor state
  logic [31:0] hash_h[8];
  logic [31:0] block_w[16];
  int          block_bytes;
  logic [63:0] msg_bits;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] v[8];
    logic [31:0] w, w15, w2, t1, t2;
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = block_w[t];
      end else begin
        w15 = block_w[(t - 15) & 15];
        w2 = block_w[(t - 2) & 15];
        w = block_w[t & 15] + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3))
            + block_w[(t - 7) & 15] + (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10));
        block_w[t & 15] = w;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + sha_pkg::RoundK[t] + w;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic pack_byte(input logic [7:0] b);
    int idx;
    int sh;
    idx = block_bytes >> 2;
    sh = 24 - 8 * (block_bytes & 3);
    if ((block_bytes & 3) == 0) block_w[idx] = '0;
    block_w[idx] |= 32'(b) << sh;
    block_bytes++;
    if (block_bytes == 64) begin
      compress_block();
      block_bytes = 0;
    end
  endtask

  // Predict the digest words caused by one accepted request
  task automatic predict_digest(input msg_word_t m);
    int nb;
    logic [63:0] len;
    digest_word_t d;
    nb = (m.nbytes > 4) ? 4 : int'(m.nbytes);
    for (int i = 0; i < nb; i++) pack_byte(m.data[31 - 8 * i -: 8]);
    msg_bits += 64'(nb * 8);
    if (!m.last) return;
    len = msg_bits;
    pack_byte(sha_pkg::PadByte);
    while (block_bytes != 56) pack_byte(8'h00);
    block_w[14] = len[63:32];
    block_w[15] = len[31:0];
    compress_block();
    for (int k = 0; k < 8; k++) begin
      d.word = hash_h[k];
      d.index = 3'(k);
      d.last = (k == 7);
      digest_expect.push_back(d);
    end
    for (int i = 0; i < 8; i++) hash_h[i] = sha_pkg::HashInit[i];
    block_bytes = 0;
    msg_bits = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Queue one message of n words; the final word carries 0..7 byte count
  task automatic queue_message(input int n, input bit rand_short);
    msg_word_t m;
    for (int i = 0; i < n; i++) begin
      m.data = $urandom;
      m.last = (i == n - 1);
      m.nbytes = 3'd4;
      if (m.last || (rand_short && $urandom_range(0, 3) == 0))
        m.nbytes = 3'($urandom_range(0, 7));
      pending_words.push_back(m);
    end
  endtask

  // Driver: bursts of pushes with random gaps; hold when a drain is requested
  int burst_left;
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      data_word_i <= '0;
      valid_bytes_i <= '0;
      last_word_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      msg_word_t m;
      bit take;
      bit offer;
      take = push && !full;
      if (take) begin
        predict_digest({data_word_i, valid_bytes_i, last_word_i});
        void'(pending_words.pop_front());
      end
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 12);
        if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 8);
      end else begin
        offer = 1'b1;
        if (take) burst_left <= burst_left - 1;
      end
      if (hold_for_drain) offer = 1'b0;
      if (offer && pending_words.size() > 0) begin
        m = pending_words[0];
        push <= 1'b1;
        data_word_i <= m.data;
        valid_bytes_i <= m.nbytes;
        last_word_i <= m.last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: check popped words; random stalls by pattern plus a long hold
  int stall_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      stall_phase <= 0;
    end else begin
      digest_word_t want;
      if (pop && !empty) begin
        if (digest_expect.size() == 0) begin
          report_mismatch("unexpected digest word", digest_word_o, 32'h0);
        end else begin
          want = digest_expect.pop_front();
          if (digest_word_o !== want.word)
            report_mismatch("digest_word", digest_word_o, want.word);
          if (word_index_o !== want.index)
            report_mismatch("word_index", 32'(word_index_o), 32'(want.index));
          if (digest_last_o !== want.last)
            report_mismatch("digest_last", 32'(digest_last_o), 32'(want.last));
        end
      end
      stall_phase <= (stall_phase + 1) % 23;
      if (stall_hold > 0) pop <= 1'b0;
      else if (stall_phase < 8) pop <= 1'b1;
      else pop <= ($urandom_range(0, 2) != 0);
    end
  end

  // Long receiver hold, counted in cycles, during the random phase
  initial begin
    stall_hold = 0;
    wait (rst_ni);
    wait (hold_for_drain);
    wait (!hold_for_drain);
    repeat (100) @(posedge clk_i);
    stall_hold = 1;
    repeat (2500) @(posedge clk_i);
    stall_hold = 0;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    error_count = 0;
    hold_for_drain = 1'b0;
    for (int i = 0; i < 8; i++) hash_h[i] = sha_pkg::HashInit[i];
    for (int i = 0; i < 16; i++) block_w[i] = '0;
    block_bytes = 0;
    msg_bits = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty message, one full word, extremes, oversize byte counts,
    // short word before the end, and lengths around the padding boundary
    pending_words.push_back('{32'h0, 3'd0, 1'b1});
    pending_words.push_back('{32'hffffffff, 3'd4, 1'b1});
    pending_words.push_back('{32'h00000000, 3'd7, 1'b0});
    pending_words.push_back('{32'hffffffff, 3'd5, 1'b1});
    pending_words.push_back('{32'h61626364, 3'd1, 1'b0});
    pending_words.push_back('{32'hdeadbeef, 3'd2, 1'b0});
    pending_words.push_back('{32'h12345678, 3'd3, 1'b1});
    pending_words.push_back('{32'haaaaaaaa, 3'd6, 1'b1});
    queue_message(14, 1'b0);

    // Pause until every digest has come
    wait (pending_words.size() == 0);
    hold_for_drain = 1'b1;
    wait (digest_expect.size() == 0);
    repeat (200) @(posedge clk_i);
    hold_for_drain = 1'b0;

    // Random messages; most short, a few spanning several blocks
    for (int n = 0; n < 10; n++) begin
      if ($urandom_range(0, 5) == 0) queue_message($urandom_range(15, 34), 1'b1);
      else queue_message($urandom_range(1, 8), $urandom_range(0, 1));
    end

    wait (pending_words.size() == 0);
    wait (digest_expect.size() == 0);
    repeat (300) @(posedge clk_i);
    if (error_count == 0 && digest_expect.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
sv/sha_pkg.sv
sv/sha_front.sv
sv/sha_core.sv
sv/sha256_hash_engine_top.sv
sim/testbench.sv
